// ===== sv/povlst_pkg.sv =====
// Shared types and constants for the line scanner and period tracker.
// Used by the interfaces, the register block, the period unit and the top level.
`default_nettype none

package povlst_pkg;

  localparam int LINE_W    = 40;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  // Input operation codes; the fourth code is unused and changes nothing.
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_HALL  = 2'd1,
    OP_WRITE = 2'd2
  } op_t;

  // Register index, taken from bit 2 of the byte address.
  localparam logic REG_LINE_OFFSET    = 1'b0;
  localparam logic REG_JUMP_THRESHOLD = 1'b1;

  localparam logic [7:0]  OFFSET_RST    = 8'd168;
  localparam logic [7:0]  THRESHOLD_RST = 8'd4;
  localparam logic [15:0] PERIOD_RST    = 16'd1200;

  // Phases of a hall event in the period unit.
  typedef enum logic [1:0] {
    PH_SUM,
    PH_DIV,
    PH_BLEND
  } hall_phase_t;

  typedef struct packed {
    logic [7:0] lag_start;
    logic [7:0] jump_threshold;
  } cfg_t;

  // From the top level to the period unit.
  typedef struct packed {
    logic        busy;     // input stage holds a word
    logic [1:0]  op;
    logic [15:0] cap;
    logic        advance;  // input stage word moves to the result register
  } pu_req_t;

  // From the period unit back to the top level.
  typedef struct packed {
    logic        done;
    logic [15:0] period_after;
    logic        jumped;
  } pu_rsp_t;

endpackage

`default_nettype wire

// ===== sv/povlst_if.sv =====
// Valid/ready channel interfaces for input words and result words.
// Depends on povlst_pkg for the line width.
`default_nettype none

interface povlst_in_if;
  import povlst_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        op;
  logic [15:0]       capture_count;
  logic [7:0]        line_index;
  logic [LINE_W-1:0] line_data;

  modport source (output valid, op, capture_count, line_index, line_data, input ready);
  modport sink   (input valid, op, capture_count, line_index, line_data, output ready);
endinterface

interface povlst_out_if;
  import povlst_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        kind;
  logic [LINE_W-1:0] shift_word;
  logic [15:0]       period_top;
  logic              period_jumped;

  modport source (output valid, kind, shift_word, period_top, period_jumped, input ready);
  modport sink   (input valid, kind, shift_word, period_top, period_jumped, output ready);
endinterface

`default_nettype wire

// ===== sv/pov_line_scanner_period_tracker.sv =====
// Line engine top level: frame store, line counters and result register.
// Depends on povlst_pkg, povlst_if, povlst_ram, povlst_cfg and povlst_period.
//
// Usage. Words enter on req (valid/ready) and one result word leaves on res
// for every input word, in order. A write word stores a 40-bit line in the
// frame store; a line tick returns the shift word built from the lag line
// (upper bytes) and the lead line (lower bytes) and steps both counters; a
// hall word closes a turn, updates the smoothed period and reloads the
// counters from the line offset. Two registers sit on an APB-style port at
// byte addresses 0 (line offset) and 4 (jump threshold), writable while idle.
//
// Timing. A tick or write word is accepted and read from the frame store at the
// same edge, then moves from the input stage into the result register; one word
// can be taken every cycle while res is not stalled. A hall word holds in the
// input stage through three steps (saturating sum with reciprocal multiply,
// quotient, blend), and ready stays low during the first two of them.
// Reset returns the counters, accumulator and period to their starting values
// and marks every line invalid: a line never written since reset reads as
// zero, with no clearing pass. When res is stalled the finished result is
// held, one further word is still taken into the input stage, and ready then
// drops until res moves.
`default_nettype none

module pov_line_scanner_period_tracker #(
  parameter int LINES      = 240,
  parameter int LEAD_LINES = 60
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  povlst_in_if.sink                           req,
  povlst_out_if.source                        res,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [povlst_pkg::PADDR_W-1:0] paddr,
  input  wire logic [povlst_pkg::PDATA_W-1:0] pwdata,
  output logic      [povlst_pkg::PDATA_W-1:0] prdata,
  output logic                                pready
);
  import povlst_pkg::*;

  localparam int CW       = $clog2(LINES);
  localparam int LEAD_MOD = LEAD_LINES % LINES;

  cfg_t    cfg;
  pu_req_t pu_req;
  pu_rsp_t pu_rsp;

  // Line counters, a quarter turn apart, updated as each word is accepted.
  logic [CW-1:0]    lead;
  logic [CW-1:0]    lag;
  logic [CW-1:0]    lead_next;
  logic [CW-1:0]    lag_next;
  logic [CW-1:0]    lag_load;
  logic [CW:0]      lead_sum;
  logic [LINES-1:0] line_vld;

  // Input stage.
  logic        a_valid;
  logic [1:0]  a_op;
  logic [15:0] a_cap;
  logic        lead_vld;
  logic        lag_vld;

  // Result register.
  logic              b_valid;
  logic [1:0]        kind;
  logic [LINE_W-1:0] shift_word;
  logic [15:0]       period_top;
  logic              period_jumped;

  logic              take;
  logic              advance;
  logic              store;
  logic [LINE_W-1:0] rd_lead;
  logic [LINE_W-1:0] rd_lag;
  logic [LINE_W-1:0] lead_line;
  logic [LINE_W-1:0] lag_line;
  logic [LINE_W-1:0] word;
  logic [CW-1:0]     off_mod [256];

  // Line offset reduced modulo the line count, as a constant table.
  for (genvar g = 0; g < 256; g++) begin : g_off
    assign off_mod[g] = CW'(g % LINES);
  end

  povlst_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign advance   = a_valid && pu_rsp.done && (!b_valid || res.ready);
  assign req.ready = !a_valid || advance;
  assign take      = req.valid && req.ready;
  assign store     = take && (req.op == OP_WRITE) && (req.line_index < 8'(LINES));

  povlst_ram #(
    .WIDTH (LINE_W),
    .DEPTH (LINES)
  ) u_frame (
    .clk     (clk),
    .we      (store),
    .waddr   (req.line_index[CW-1:0]),
    .wdata   (req.line_data),
    .re      (take),
    .raddr_a (lead),
    .raddr_b (lag),
    .rdata_a (rd_lead),
    .rdata_b (rd_lag)
  );

  assign pu_req.busy    = a_valid;
  assign pu_req.op      = a_op;
  assign pu_req.cap     = a_cap;
  assign pu_req.advance = advance;

  povlst_period #(
    .LINES (LINES)
  ) u_period (
    .clk            (clk),
    .rst            (rst),
    .req            (pu_req),
    .jump_threshold (cfg.jump_threshold),
    .rsp            (pu_rsp)
  );

  // Counter steps: advance on a tick, reload from the offset on a hall word.
  always_comb begin
    lag_load = off_mod[cfg.lag_start];
    lead_sum = {1'b0, lag_load} + (CW+1)'(LEAD_MOD);
    lead_next = lead;
    lag_next  = lag;
    case (req.op)
      OP_TICK: begin
        lead_next = (lead == CW'(LINES - 1)) ? '0 : lead + CW'(1);
        lag_next  = (lag == CW'(LINES - 1)) ? '0 : lag + CW'(1);
      end
      OP_HALL: begin
        lag_next  = lag_load;
        lead_next = (lead_sum >= (CW+1)'(LINES)) ? CW'(lead_sum - (CW+1)'(LINES))
                                                 : lead_sum[CW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lead     <= CW'(LEAD_MOD);
      lag      <= '0;
      line_vld <= '0;
      a_valid  <= 1'b0;
    end else begin
      if (take) begin
        lead    <= lead_next;
        lag     <= lag_next;
        a_valid <= 1'b1;
      end else if (advance) begin
        a_valid <= 1'b0;
      end
      if (store) begin
        line_vld[req.line_index[CW-1:0]] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      a_op     <= req.op;
      a_cap    <= req.capture_count;
      lead_vld <= line_vld[lead];
      lag_vld  <= line_vld[lag];
    end
  end

  // Lines never written since reset read as zero.
  assign lead_line = lead_vld ? rd_lead : '0;
  assign lag_line  = lag_vld ? rd_lag : '0;

  always_comb begin
    word = '0;
    if (a_op == OP_TICK) begin
      word = {lag_line[39:24], lag_line[23:20], lead_line[19:16], lead_line[15:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (advance) begin
      b_valid <= 1'b1;
    end else if (res.ready) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      kind          <= a_op;
      shift_word    <= word;
      period_top    <= pu_rsp.period_after - 16'd1;
      period_jumped <= pu_rsp.jumped;
    end
  end

  assign res.valid         = b_valid;
  assign res.kind          = kind;
  assign res.shift_word    = shift_word;
  assign res.period_top    = period_top;
  assign res.period_jumped = period_jumped;

`ifndef ASSERT_OFF
  a_stall_means_busy: assert property (@(posedge clk) disable iff (rst)
    !req.ready |-> a_valid)
    else $error("input stalled with an empty input stage");

  a_counters_in_range: assert property (@(posedge clk) disable iff (rst)
    (32'(lead) < LINES) && (32'(lag) < LINES))
    else $error("line counter out of range");

  a_counters_apart: assert property (@(posedge clk) disable iff (rst)
    ((32'(lag) + LEAD_MOD) == 32'(lead)) || ((32'(lag) + LEAD_MOD) == 32'(lead) + LINES))
    else $error("lead and lag counters lost their spacing");

  a_hall_holds_input: assert property (@(posedge clk) disable iff (rst)
    (take && req.op == OP_HALL) |=> !req.ready)
    else $error("word accepted while a hall word was still being worked");
`endif

endmodule

`default_nettype wire

// ===== sv/povlst_ram.sv =====
// Generic RAM: one write port and two read ports with registered read data.
// No dependencies.
`default_nettype none

module povlst_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 240
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

`default_nettype wire

// ===== sv/povlst_cfg.sv =====
// APB-style configuration registers: line offset and jump threshold.
// Depends on povlst_pkg for the register indexes and reset values.
`default_nettype none

module povlst_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [povlst_pkg::PADDR_W-1:0] paddr,
  input  wire logic [povlst_pkg::PDATA_W-1:0] pwdata,
  output logic      [povlst_pkg::PDATA_W-1:0] prdata,
  output logic                               pready,
  output povlst_pkg::cfg_t                   cfg
);
  import povlst_pkg::*;

  logic [7:0] lag_start;
  logic [7:0] jump_threshold;
  logic       wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      lag_start      <= OFFSET_RST;
      jump_threshold <= THRESHOLD_RST;
    end else if (wr) begin
      case (paddr[2])
        REG_LINE_OFFSET:    lag_start      <= pwdata[7:0];
        REG_JUMP_THRESHOLD: jump_threshold <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_LINE_OFFSET:    prdata = {24'd0, lag_start};
      REG_JUMP_THRESHOLD: prdata = {24'd0, jump_threshold};
      default:            prdata = '0;
    endcase
  end

  assign cfg.lag_start      = lag_start;
  assign cfg.jump_threshold = jump_threshold;

endmodule

`default_nettype wire

// ===== sv/povlst_period.sv =====
// Period unit: turn-time accumulator, smoothed line period and the hall sequence.
// Depends on povlst_pkg for the request/response structs and phase enum.
`default_nettype none

module povlst_period #(
  parameter int LINES = 240
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire povlst_pkg::pu_req_t req,
  input  wire logic [7:0]          jump_threshold,
  output povlst_pkg::pu_rsp_t      rsp
);
  import povlst_pkg::*;

  // Division by LINES-1 as a multiply by a 40-bit reciprocal, exact for
  // any 32-bit dividend because the rounding error stays below 2^8.
  localparam int          DIV      = LINES - 1;
  localparam logic [39:0] RECIP    = 40'(((64'd1 << 40) + 64'(DIV) - 64'd1) / 64'(DIV));
  localparam logic [15:0] RECIP_LO = RECIP[15:0];
  localparam logic [23:0] RECIP_HI = RECIP[39:16];

  hall_phase_t phase, phase_next;
  logic [31:0] turn_time;
  logic [15:0] period;
  logic [55:0] prod_hi;
  logic [47:0] prod_lo;
  logic [31:0] fresh;

  logic        is_hall;
  logic [31:0] hall_sum;
  logic [71:0] prod_sum;
  logic [31:0] diff;
  logic [34:0] blend;
  logic [31:0] cand;
  logic [15:0] period_new;
  logic        jump;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  assign is_hall  = req.busy && (req.op == OP_HALL);
  assign hall_sum = sat_add(turn_time, 32'(req.cap));
  assign prod_sum = {prod_hi, 16'd0} + 72'(prod_lo);

  // Blend step, worked on the registered quotient.
  always_comb begin
    diff  = (fresh > 32'(period)) ? fresh - 32'(period) : 32'(period) - fresh;
    jump  = diff > 32'(jump_threshold);
    blend = (35'(period) * 35'd7 + 35'(fresh)) >> 3;
    cand  = jump ? fresh : blend[31:0];
    if (jump ? 1'b0 : (blend[34:32] != 3'd0)) begin
      period_new = 16'hFFFF;
    end else if (cand == 32'd0) begin
      period_new = 16'd1;
    end else if (cand > 32'd65535) begin
      period_new = 16'hFFFF;
    end else begin
      period_new = cand[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_SUM;
    end else begin
      phase <= phase_next;
    end
  end

  always_comb begin
    phase_next       = phase;
    rsp.done         = 1'b1;
    rsp.period_after = period;
    rsp.jumped       = 1'b0;
    case (phase)
      PH_SUM: begin
        if (is_hall) begin
          phase_next = PH_DIV;
          rsp.done   = 1'b0;
        end
      end
      PH_DIV: begin
        phase_next = PH_BLEND;
        rsp.done   = 1'b0;
      end
      PH_BLEND: begin
        rsp.period_after = period_new;
        rsp.jumped       = jump;
        if (req.advance) begin
          phase_next = PH_SUM;
        end
      end
      default: phase_next = PH_SUM;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      turn_time <= '0;
      period    <= PERIOD_RST;
    end else if (req.advance) begin
      case (req.op)
        OP_TICK: turn_time <= sat_add(turn_time, 32'(period));
        OP_HALL: begin
          turn_time <= '0;
          period    <= period_new;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (phase == PH_SUM && is_hall) begin
      prod_hi <= 56'(hall_sum) * 56'(RECIP_HI);
      prod_lo <= 48'(hall_sum) * 48'(RECIP_LO);
    end
    if (phase == PH_DIV) begin
      fresh <= prod_sum[71:40];
    end
  end

`ifndef ASSERT_OFF
  a_div_after_sum: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_SUM && is_hall) |=> (phase == PH_DIV))
    else $error("hall sequence did not move to the divide phase");

  a_no_retire_mid_hall: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_SUM && is_hall) |-> !req.advance)
    else $error("hall word retired before its period was worked out");

  a_period_nonzero: assert property (@(posedge clk) disable iff (rst)
    period != 16'd0)
    else $error("line period reached zero");
`endif

endmodule

`default_nettype wire

// ===== test/tb_pov_line_scanner_period_tracker.sv =====
// Self-checking testbench for the line engine and period tracker.
// Depends on povlst_pkg, the povlst_in_if/povlst_out_if channels and the RTL top level.
// A scoreboard class predicts every result word; plain tasks drive words and registers.
`default_nettype none

module tb_pov_line_scanner_period_tracker;
  timeunit 1ns;
  timeprecision 1ps;
  import povlst_pkg::*;

  localparam int LINES      = 240;
  localparam int LEAD_LINES = 60;
  // The fourth op code is not decoded by the block; it must leave all state alone.
  localparam logic [1:0]  OP_SPARE  = 2'd3;
  localparam logic [31:0] ACC_MAX   = 32'hFFFF_FFFF;
  localparam int          RUN_LIMIT = 1_000_000;
  // A hall word passes through its sum, quotient and blend steps before it comes out; SETTLE is ample.
  localparam int          SETTLE    = 8;

  typedef struct packed {
    logic [1:0]        kind;
    logic [LINE_W-1:0] shift_word;
    logic [15:0]       period_top;
    logic              period_jumped;
  } line_result_t;

  // Scoreboard: keeps its own copy of the frame store, the two line counters, the
  // turn-time accumulator and the smoothed period, and queues the result word that
  // each accepted input word should produce.
  class scan_period_model;
    logic [LINE_W-1:0] frame [LINES];
    int unsigned       lead_line;
    int unsigned       lag_line;
    logic [31:0]       turn_acc;
    logic [15:0]       cur_period;
    logic [7:0]        offset_reg;
    logic [7:0]        thresh_reg;
    line_result_t      due_results[$];
    int                fail_count;

    function void clear();
      foreach (frame[i]) frame[i] = '0;
      lead_line   = LEAD_LINES % LINES;
      lag_line    = 0;
      turn_acc    = '0;
      cur_period  = PERIOD_RST;
      offset_reg  = OFFSET_RST;
      thresh_reg  = THRESHOLD_RST;
      due_results.delete();
      fail_count  = 0;
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    // Capture count that would make the next hall event see a fresh period of
    // cur_period + delta, clipped to what the 16-bit field can carry.
    function logic [15:0] cap_for(int delta);
      longint target;
      longint c;
      target = longint'(LINES - 1) * (longint'(cur_period) + delta);
      if (target < 0) target = 0;
      c = target - longint'(turn_acc);
      if (c < 0) c = 0;
      else if (c > 65535) c = 65535;
      return c[15:0];
    endfunction

    function void take_word(logic [1:0] op, logic [15:0] cap, logic [7:0] idx,
                            logic [LINE_W-1:0] data);
      line_result_t      r;
      logic [LINE_W-1:0] lead_d;
      logic [LINE_W-1:0] lag_d;
      longint unsigned   sum;
      longint unsigned   fresh;
      longint unsigned   diff;
      longint unsigned   next_period;
      r.kind          = op;
      r.shift_word    = '0;
      r.period_jumped = 1'b0;
      case (op)
        OP_TICK: begin
          lead_d   = frame[lead_line];
          lag_d    = frame[lag_line];
          sum      = 64'(turn_acc) + 64'(cur_period);
          turn_acc = (sum > 64'(ACC_MAX)) ? ACC_MAX : sum[31:0];
          // Lag line gives bytes 4, 3 and the high nibble of byte 2; the lead line
          // gives the low nibble of byte 2 and bytes 1, 0.
          r.shift_word = {lag_d[39:20], lead_d[19:0]};
          lead_line    = (lead_line + 1) % LINES;
          lag_line     = (lag_line + 1) % LINES;
        end
        OP_HALL: begin
          sum      = 64'(turn_acc) + 64'(cap);
          turn_acc = (sum > 64'(ACC_MAX)) ? ACC_MAX : sum[31:0];
          fresh    = 64'(turn_acc) / (LINES - 1);
          diff     = (fresh > cur_period) ? fresh - cur_period : cur_period - fresh;
          if (diff > thresh_reg) begin
            next_period     = fresh;
            r.period_jumped = 1'b1;
          end else begin
            next_period = (64'd7 * cur_period + fresh) / 64'd8;
          end
          if (next_period < 1) next_period = 1;
          else if (next_period > 65535) next_period = 65535;
          cur_period  = next_period[15:0];
          turn_acc    = '0;
          lag_line    = offset_reg % LINES;
          lead_line   = (lag_line + LEAD_LINES) % LINES;
        end
        OP_WRITE: begin
          if (idx < LINES) frame[idx] = data;
        end
        default: ;
      endcase
      r.period_top = cur_period - 16'd1;
      due_results.push_back(r);
    endfunction

    function void check_word(line_result_t got);
      line_result_t want;
      if (due_results.size() == 0) begin
        $error("result word arrived with nothing expected");
        fail_count++;
        return;
      end
      want = due_results.pop_front();
      if (got.kind !== want.kind) begin
        $error("kind mismatch: expected %0d, got %0d", want.kind, got.kind);
        fail_count++;
      end
      if (got.shift_word !== want.shift_word) begin
        $error("shift_word mismatch: expected %h, got %h", want.shift_word, got.shift_word);
        fail_count++;
      end
      if (got.period_top !== want.period_top) begin
        $error("period_top mismatch: expected %0d, got %0d", want.period_top, got.period_top);
        fail_count++;
      end
      if (got.period_jumped !== want.period_jumped) begin
        $error("period_jumped mismatch: expected %0d, got %0d",
               want.period_jumped, got.period_jumped);
        fail_count++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  povlst_in_if  req_ch ();
  povlst_out_if res_ch ();

  // Percentages of cycles in which the sender holds back a word and the
  // receiver refuses one; changed between phases.
  int src_idle;
  int snk_idle;
  int unsigned cycle_count = 0;
  scan_period_model model;

  pov_line_scanner_period_tracker dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .res     (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: a run that hangs on a handshake ends here as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= RUN_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Result side. Values read straight after the edge are the ones the block
  // presented before it, so a word counts as taken when valid and ready were
  // both high then. ready is redrawn once per cycle.
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
        model.check_word(line_result_t'{kind: res_ch.kind, shift_word: res_ch.shift_word,
                                        period_top: res_ch.period_top,
                                        period_jumped: res_ch.period_jumped});
      res_ch.ready <= ($urandom_range(99, 0) >= snk_idle);
    end
  end

  function automatic logic [LINE_W-1:0] rand_line();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[LINE_W-1:0];
  endfunction

  // Presents one input word and returns at the edge where the block takes it.
  // valid is left high so that a following word can go out back to back; any
  // caller that waits between words lowers it first.
  task automatic send_word(input logic [1:0] op, input logic [15:0] cap,
                           input logic [7:0] idx, input logic [LINE_W-1:0] data);
    while ($urandom_range(99, 0) < src_idle) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid         <= 1'b1;
    req_ch.op            <= op;
    req_ch.capture_count <= cap;
    req_ch.line_index    <= idx;
    req_ch.line_data     <= data;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    model.take_word(op, cap, idx, data);
  endtask

  // Fields a word does not use still carry random values.
  task automatic send_tick();
    send_word(OP_TICK, 16'($urandom), 8'($urandom), rand_line());
  endtask

  task automatic send_hall(input logic [15:0] cap);
    send_word(OP_HALL, cap, 8'($urandom), rand_line());
  endtask

  task automatic send_line(input logic [7:0] idx, input logic [LINE_W-1:0] data);
    send_word(OP_WRITE, 16'($urandom), idx, data);
  endtask

  // Holds the input back until every expected result word has been taken.
  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (model.pending() != 0) @(posedge clk);
  endtask

  // One APB write followed by a read-back of the same register.
  task automatic reg_access(input logic idx, input logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= PDATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx == REG_LINE_OFFSET) model.offset_reg = value;
    else model.thresh_reg = value;
    @(posedge clk);
    psel   <= 1'b1;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (prdata[7:0] !== value) begin
      $error("%s read back: expected %0d, got %0d",
             (idx == REG_LINE_OFFSET) ? "lag_start" : "jump_threshold", value, prdata[7:0]);
      model.fail_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Registers only change with the block idle: every result in, then a few
  // spare cycles in case a hall word is still winding down.
  task automatic set_config(input logic [7:0] offset, input logic [7:0] thresh,
                            input int src_pct, input int snk_pct);
    drain();
    repeat (SETTLE) @(posedge clk);
    reg_access(REG_LINE_OFFSET, offset);
    reg_access(REG_JUMP_THRESHOLD, thresh);
    src_idle = src_pct;
    snk_idle = snk_pct;
  endtask

  // Mostly whole turns: a run of ticks with line writes near the counters so
  // that fresh data gets scanned, closed by a hall word whose count often lands
  // around the jump threshold. The rest is single words of any op and index.
  task automatic random_items(input int goal);
    int          done_items;
    int          delta;
    int unsigned base;
    logic [1:0]  op;
    logic [7:0]  idx;
    done_items = 0;
    while (done_items < goal) begin
      if ($urandom_range(99, 0) < 70) begin
        repeat ($urandom_range(30, 1)) begin
          if ($urandom_range(99, 0) < 30) begin
            base = $urandom_range(1, 0) ? model.lag_line : model.lead_line;
            idx  = 8'((base + $urandom_range(6, 0)) % LINES);
            send_line(idx, rand_line());
          end else begin
            send_tick();
          end
          done_items++;
        end
        delta = int'($urandom_range(2 * model.thresh_reg + 6, 0)) - int'(model.thresh_reg) - 3;
        send_hall(($urandom_range(99, 0) < 60) ? model.cap_for(delta) : 16'($urandom));
        done_items++;
      end else begin
        op  = 2'($urandom_range(3, 0));
        idx = 8'($urandom_range(255, 0));
        send_word(op, 16'($urandom), idx, rand_line());
        if (op != OP_SPARE) done_items++;
      end
      // Now and then the sender waits for the pipeline to empty completely.
      if ($urandom_range(199, 0) == 0) drain();
    end
  endtask

  initial begin
    model = new;
    model.clear();
    req_ch.valid         = 1'b0;
    req_ch.op            = OP_TICK;
    req_ch.capture_count = '0;
    req_ch.line_index    = '0;
    req_ch.line_data     = '0;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    src_idle             = 28;
    snk_idle             = 56;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed words with the reset register values.
    send_tick();                                // nothing written yet: all-zero word
    send_line(8'd0, 40'hFF_FFFF_FFFF);
    send_line(8'd61, 40'hA5_5A_C3_3C_96);       // next lead line
    send_line(8'd1, 40'h5A_A5_3C_C3_69);        // next lag line
    send_line(8'd239, rand_line());
    send_line(8'd240, rand_line());             // index past the store: dropped
    send_line(8'd255, 40'hFF_FFFF_FFFF);        // likewise, all index bits high
    send_tick();                                // nibble mixing of lines 1 and 61
    send_word(OP_SPARE, 16'hFFFF, 8'hFF, 40'hFF_FFFF_FFFF);
    send_line(8'd168, 40'h0F_F0_0F_F0_0F);
    send_line(8'd228, 40'hF0_0F_F0_0F_F0);
    send_hall(16'hFFFF);                        // largest count: new period taken outright
    send_tick();                                // counters reloaded to 168 and 228
    send_hall(16'd0);
    send_hall(16'd0);                           // empty turn: period clamps to one
    send_hall(model.cap_for(0));                // turn matching the period: blended
    repeat (3) send_tick();
    send_hall(model.cap_for(int'(model.thresh_reg)));      // exactly on the threshold
    send_hall(model.cap_for(int'(model.thresh_reg) + 1));  // just past it: jump
    send_line(8'd0, 40'h00_0000_0000);

    // Random phases, each with its own register setting and idling pattern.
    set_config(8'd0, 8'd0, 28, 56);
    random_items(130);
    set_config(8'd239, 8'd255, 28, 56);
    random_items(130);
    set_config(8'd240, 8'($urandom), 56, 28);   // offset past the last line wraps
    random_items(130);
    set_config(8'd255, 8'd1, 56, 28);
    random_items(130);
    set_config(8'($urandom), 8'($urandom), 0, 0);
    random_items(135);
    set_config(OFFSET_RST, THRESHOLD_RST, 0, 0);
    random_items(130);

    // Let every outstanding result come back, then watch for stray words.
    req_ch.valid <= 1'b0;
    while (model.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (model.fail_count == 0 && model.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
sv/povlst_pkg.sv
sv/povlst_if.sv
sv/povlst_ram.sv
sv/povlst_cfg.sv
sv/povlst_period.sv
sv/pov_line_scanner_period_tracker.sv
test/tb_pov_line_scanner_period_tracker.sv
